### rtl/alc_pkg.sv
// ---------------------------------------------------------------------------
// alc_pkg: shared types and constants of the block allocator
// Payload structs, table entry layout, status and register codes.
// ---------------------------------------------------------------------------
`default_nettype none

package alc_pkg;

  localparam int ADDR_BITS = 16;
  localparam int LEN_W     = 17;
  localparam logic [LEN_W-1:0] POOL_MAX = LEN_W'(1 << ADDR_BITS);

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // fit policies
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_POOL   = 2'd1;

  // request codes
  localparam logic FUNC_FREE = 1'b1;

  typedef struct packed {
    logic             func;
    logic [LEN_W-1:0] request_length;
    logic [15:0]      block_address;
  } alc_in_t;

  typedef struct packed {
    logic [15:0]      granted_address;
    logic [1:0]       status;
    logic [LEN_W-1:0] free_bytes;
  } alc_out_t;

  typedef struct packed {
    logic [1:0]       index;
    logic [LEN_W-1:0] data;
  } alc_cfg_t;

  // one table entry, hole or allocated block
  typedef struct packed {
    logic             valid;
    logic [15:0]      start;
    logic [LEN_W-1:0] length;
  } alc_ent_t;

endpackage : alc_pkg

`default_nettype wire

### rtl/alc_tables.sv
// ---------------------------------------------------------------------------
// alc_tables: hole table and allocation table
// Register arrays with one shared scan read index and one write port each.
// ---------------------------------------------------------------------------
`default_nettype none

module alc_tables import alc_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clear,
  input  wire logic [IW-1:0] rd_idx,
  output alc_ent_t           hole_rd,
  output alc_ent_t           used_rd,
  input  wire logic          hole_we,
  input  wire logic [IW-1:0] hole_widx,
  input  wire alc_ent_t      hole_wdata,
  input  wire logic          used_we,
  input  wire logic [IW-1:0] used_widx,
  input  wire alc_ent_t      used_wdata
);

  logic [15:0]      hole_start_r [MAX_BLOCKS];
  logic [LEN_W-1:0] hole_len_r   [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] hole_vld_r;
  logic [15:0]      used_start_r [MAX_BLOCKS];
  logic [LEN_W-1:0] used_len_r   [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] used_vld_r;

  // valid bits: cleared by reset and by a pool resize
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      hole_vld_r <= '0;
      used_vld_r <= '0;
    end else begin
      if (hole_we) hole_vld_r[hole_widx] <= hole_wdata.valid;
      if (used_we) used_vld_r[used_widx] <= used_wdata.valid;
    end
  end

  // payload fields
  always_ff @(posedge clk) begin
    if (hole_we) begin
      hole_start_r[hole_widx] <= hole_wdata.start;
      hole_len_r[hole_widx]   <= hole_wdata.length;
    end
    if (used_we) begin
      used_start_r[used_widx] <= used_wdata.start;
      used_len_r[used_widx]   <= used_wdata.length;
    end
  end

  // scan read
  assign hole_rd = '{valid: hole_vld_r[rd_idx], start: hole_start_r[rd_idx],
                     length: hole_len_r[rd_idx]};
  assign used_rd = '{valid: used_vld_r[rd_idx], start: used_start_r[rd_idx],
                     length: used_len_r[rd_idx]};

endmodule : alc_tables

`default_nettype wire

### rtl/alc_ctrl.sv
// ---------------------------------------------------------------------------
// alc_ctrl: request sequencer
// Scans the tables one entry a cycle through a shared compare unit, then
// commits the table updates and registers the result.
// ---------------------------------------------------------------------------
`default_nettype none

module alc_ctrl import alc_pkg::*; #(
  parameter int MAX_BLOCKS = 16,
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire alc_in_t       in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output alc_out_t           out_data,
  input  wire logic          cfg_valid,
  input  wire alc_cfg_t      cfg_req,
  output logic               clear,
  output logic [IW-1:0]      rd_idx,
  input  wire alc_ent_t      hole_rd,
  input  wire alc_ent_t      used_rd,
  output logic               hole_we,
  output logic [IW-1:0]      hole_widx,
  output alc_ent_t           hole_wdata,
  output logic               used_we,
  output logic [IW-1:0]      used_widx,
  output alc_ent_t           used_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ASCAN = 3'd1;
  localparam logic [2:0] S_ADEC  = 3'd2;
  localparam logic [2:0] S_UFIND = 3'd3;
  localparam logic [2:0] S_HSCAN = 3'd4;
  localparam logic [2:0] S_HDEC  = 3'd5;
  localparam logic [2:0] S_WR2   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [IW-1:0] LAST = IW'(MAX_BLOCKS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             func_r;
  logic [LEN_W-1:0] len_r;
  logic [15:0]      addr_r;
  logic [1:0]       policy_r;
  logic [LEN_W-1:0] pool_r, top_r, avail_r;
  logic [LEN_W-1:0] top_nxt, avail_nxt;

  // scan findings
  logic             best_f_r, slot_f_r, u_f_r, bef_f_r, aft_f_r, emp_f_r;
  logic [IW-1:0]    best_i_r, slot_i_r, u_i_r, bef_i_r, aft_i_r, emp_i_r;
  logic [15:0]      best_s_r, bef_s_r;
  logic [LEN_W-1:0] best_l_r, u_l_r, bef_l_r, aft_l_r;

  logic [1:0]       status_r, status_nxt;
  logic [15:0]      grant_r, grant_nxt;
  logic             out_valid_r;
  alc_out_t         out_r;

  // shared compare unit
  logic             fits, better;
  logic [LEN_W:0]   hole_end, free_end;
  logic             at_before, at_after;

  assign fits = hole_rd.valid && (hole_rd.length >= len_r);

  always_comb begin
    unique case (policy_r)
      POL_BEST:  better = (hole_rd.length < best_l_r) ||
                          ((hole_rd.length == best_l_r) && (hole_rd.start < best_s_r));
      POL_WORST: better = (hole_rd.length > best_l_r) ||
                          ((hole_rd.length == best_l_r) && (hole_rd.start < best_s_r));
      default:   better = hole_rd.start < best_s_r;
    endcase
  end

  assign hole_end  = {2'b00, hole_rd.start} + {1'b0, hole_rd.length};
  assign free_end  = {2'b00, addr_r} + {1'b0, u_l_r};
  assign at_before = hole_end == {2'b00, addr_r};
  assign at_after  = {2'b00, hole_rd.start} == free_end;

  assign in_ready = state_r == S_IDLE;
  assign rd_idx   = idx_r;
  assign clear    = cfg_valid && (cfg_req.index == REG_POOL);

  // sequencer and commit logic
  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    grant_nxt  = grant_r;
    top_nxt    = top_r;
    avail_nxt  = avail_r;
    hole_we    = 1'b0;
    hole_widx  = best_i_r;
    hole_wdata = '{valid: 1'b0, start: '0, length: '0};
    used_we    = 1'b0;
    used_widx  = slot_i_r;
    used_wdata = '{valid: 1'b0, start: '0, length: '0};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt    = '0;
          grant_nxt  = '0;
          status_nxt = ST_OK;
          if (in_data.func == FUNC_FREE) begin
            state_nxt = S_UFIND;
          end else if (in_data.request_length == '0) begin
            status_nxt = ST_NOSPACE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_ASCAN;
          end
        end
      end
      S_ASCAN, S_UFIND, S_HSCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST) begin
          idx_nxt = '0;
          unique case (state_r)
            S_ASCAN: state_nxt = S_ADEC;
            S_UFIND: state_nxt = S_HSCAN;
            default: state_nxt = S_HDEC;
          endcase
        end
        if ((state_r == S_UFIND) && (idx_r == LAST) && !u_f_r &&
            !(used_rd.valid && used_rd.start == addr_r)) begin
          status_nxt = ST_UNKNOWN;
          state_nxt  = S_DONE;
        end
      end
      S_ADEC: begin
        state_nxt = S_DONE;
        if (!slot_f_r) begin
          status_nxt = ST_FULL;
        end else if (best_f_r) begin
          // split the chosen hole from its low end
          grant_nxt  = best_s_r;
          hole_we    = 1'b1;
          hole_widx  = best_i_r;
          hole_wdata = '{valid: best_l_r != len_r,
                         start: best_s_r + len_r[15:0],
                         length: best_l_r - len_r};
          used_we    = 1'b1;
          used_wdata = '{valid: 1'b1, start: best_s_r, length: len_r};
          avail_nxt  = (avail_r >= len_r) ? avail_r - len_r : '0;
        end else if ((top_r > pool_r) || ((pool_r - top_r) < len_r)) begin
          status_nxt = ST_NOSPACE;
        end else begin
          // take bytes from the top region
          grant_nxt  = top_r[15:0];
          top_nxt    = top_r + len_r;
          used_we    = 1'b1;
          used_wdata = '{valid: 1'b1, start: top_r[15:0], length: len_r};
          avail_nxt  = (avail_r >= len_r) ? avail_r - len_r : '0;
        end
      end
      S_HDEC: begin
        state_nxt  = S_DONE;
        used_widx  = u_i_r;
        used_wdata = '{valid: 1'b0, start: addr_r, length: u_l_r};
        if (bef_f_r) begin
          hole_we    = 1'b1;
          hole_widx  = bef_i_r;
          hole_wdata = '{valid: 1'b1, start: bef_s_r,
                         length: bef_l_r + u_l_r + (aft_f_r ? aft_l_r : '0)};
          if (aft_f_r) state_nxt = S_WR2;
        end else if (aft_f_r) begin
          hole_we    = 1'b1;
          hole_widx  = aft_i_r;
          hole_wdata = '{valid: 1'b1, start: addr_r, length: aft_l_r + u_l_r};
        end else if (emp_f_r) begin
          hole_we    = 1'b1;
          hole_widx  = emp_i_r;
          hole_wdata = '{valid: 1'b1, start: addr_r, length: u_l_r};
        end else begin
          status_nxt = ST_FULL;
        end
        if (bef_f_r || aft_f_r || emp_f_r) begin
          used_we   = 1'b1;
          avail_nxt = avail_r + u_l_r;
        end
      end
      S_WR2: begin
        // drop the merged upper neighbor
        hole_we    = 1'b1;
        hole_widx  = aft_i_r;
        hole_wdata = '{valid: 1'b0, start: '0, length: '0};
        state_nxt  = S_DONE;
      end
      default: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      policy_r    <= '0;
      pool_r      <= POOL_MAX;
      top_r       <= '0;
      avail_r     <= POOL_MAX;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      top_r   <= top_nxt;
      avail_r <= avail_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_req.index == REG_POLICY) begin
        policy_r <= cfg_req.data[1:0];
      end
      if (clear) begin
        pool_r  <= (cfg_req.data > POOL_MAX) ? POOL_MAX : cfg_req.data;
        avail_r <= (cfg_req.data > POOL_MAX) ? POOL_MAX : cfg_req.data;
        top_r   <= '0;
      end
    end
  end

  // request payload and scan findings
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    grant_r  <= grant_nxt;
    if (state_r == S_IDLE) begin
      func_r   <= in_data.func;
      len_r    <= in_data.request_length;
      addr_r   <= in_data.block_address;
      best_f_r <= 1'b0;
      slot_f_r <= 1'b0;
      u_f_r    <= 1'b0;
      bef_f_r  <= 1'b0;
      aft_f_r  <= 1'b0;
      emp_f_r  <= 1'b0;
    end
    if (state_r == S_ASCAN) begin
      if (!used_rd.valid && !slot_f_r) begin
        slot_f_r <= 1'b1;
        slot_i_r <= idx_r;
      end
      if (fits && (!best_f_r || better)) begin
        best_f_r <= 1'b1;
        best_i_r <= idx_r;
        best_s_r <= hole_rd.start;
        best_l_r <= hole_rd.length;
      end
    end
    if (state_r == S_UFIND && !u_f_r && used_rd.valid && used_rd.start == addr_r) begin
      u_f_r <= 1'b1;
      u_i_r <= idx_r;
      u_l_r <= used_rd.length;
    end
    if (state_r == S_HSCAN) begin
      if (!hole_rd.valid) begin
        if (!emp_f_r) begin
          emp_f_r <= 1'b1;
          emp_i_r <= idx_r;
        end
      end else if (at_before) begin
        bef_f_r <= 1'b1;
        bef_i_r <= idx_r;
        bef_s_r <= hole_rd.start;
        bef_l_r <= hole_rd.length;
      end else if (at_after) begin
        aft_f_r <= 1'b1;
        aft_i_r <= idx_r;
        aft_l_r <= hole_rd.length;
      end
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r <= '{granted_address: (func_r == FUNC_FREE) ? 16'd0 : grant_r,
                 status: status_r, free_bytes: avail_r};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_top_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= pool_r) else $error("top region beyond pool");
  a_avail_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    avail_r <= pool_r) else $error("free count beyond pool");
  a_err_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r != ST_OK) |-> grant_r == '0)
    else $error("address granted on error");
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (hole_we || used_we) |-> !in_ready) else $error("table write while idle");
`endif

endmodule : alc_ctrl

`default_nettype wire

### rtl/fit_policy_block_allocator_core.sv
// ---------------------------------------------------------------------------
// fit_policy_block_allocator_core: first/best/worst fit byte pool allocator
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | alc_in_t  (func, length, address)
//   out     | output    | out_valid / out_ready | alc_out_t (address, status, free)
//   cfg     | input     | cfg_valid / cfg_ready | alc_cfg_t (index, data)
//
// An allocate scans both tables together, a free the allocation table and
// then the hole table, with one more write when two holes merge; a scan reads
// one entry per cycle. A zero-length allocate skips the scan.
// Reset is synchronous; writing pool_bytes clears both tables at once.
// The result sits in an output register; a stalled out side holds the
// sequencer in its final state and in_ready stays low until it drains.
// ---------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator_core import alc_pkg::*; #(
  parameter int MAX_BLOCKS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire alc_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output alc_out_t     out_data,
  input  wire logic    cfg_valid,
  output logic         cfg_ready,
  input  wire alc_cfg_t cfg_req
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic          clear;
  logic [IW-1:0] rd_idx, hole_widx, used_widx;
  alc_ent_t      hole_rd, used_rd, hole_wdata, used_wdata;
  logic          hole_we, used_we;

  // take configuration at any cycle
  assign cfg_ready = 1'b1;

  alc_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_req, .clear, .rd_idx, .hole_rd, .used_rd,
    .hole_we, .hole_widx, .hole_wdata, .used_we, .used_widx, .used_wdata
  );

  alc_tables #(.MAX_BLOCKS(MAX_BLOCKS)) u_tables (
    .clk, .rst_n, .clear, .rd_idx, .hole_rd, .used_rd,
    .hole_we, .hole_widx, .hole_wdata, .used_we, .used_widx, .used_wdata
  );

endmodule : fit_policy_block_allocator_core

`default_nettype wire
